FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define BMT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define BMT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/bmt_pkg.sv
// ---------------------------------------------------------------------------
// bmt_pkg
// Types, constants and helpers of the 128 x 128 bit matrix transpose store.
// ---------------------------------------------------------------------------
package bmt_pkg;

    localparam int ROWS   = 128;
    localparam int ADDR_W = 7;
    localparam int HALF_W = 64;
    localparam int ROW_W  = 2 * HALF_W;
    localparam int PAIR_W = ADDR_W - 1;
    localparam int STG_W  = 3;

    localparam logic [STG_W-1:0]  LAST_STAGE = STG_W'(ADDR_W - 1);
    localparam logic [PAIR_W-1:0] LAST_PAIR  = '1;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_TRANSPOSE = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] row_index;
        logic [HALF_W-1:0] in_low;
        logic [HALF_W-1:0] in_high;
    } cmd_t;

    typedef struct packed {
        logic [HALF_W-1:0] out_low;
        logic [HALF_W-1:0] out_high;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_WA,
        ST_WB
    } state_t;

    typedef enum logic [1:0] {
        WSEL_CMD,
        WSEL_NEW_A,
        WSEL_NEW_B
    } wsel_t;

    typedef struct packed {
        logic              busy;
        logic              rsp_pending;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        wsel_t             wr_sel;
        logic [STG_W-1:0]  stage;
    } ctrl_t;

    // Bits whose index has the stage bit clear.
    function automatic logic [ROW_W-1:0] swap_mask(input logic [STG_W-1:0] stage);
        logic [ROW_W-1:0] m;
        for (int i = 0; i < ROW_W; i++)
        begin
            m[i] = (((i >> stage) & 1) == 0);
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/bit_matrix_transpose_128.sv
// Row write: one word per cycle while not busy; a write never makes the block busy.
// Row read: result strobed in the cycle after the word is taken; one read per cycle while not busy.
// Transpose: busy through 7 stages x 64 row pairs, each pair a sequence of the
// shared swap unit and memory port: read pair, write row a, write row b.
// Reset clears the store at once through per-row valid bits; no clearing pass.
// ---------------------------------------------------------------------------
// bit_matrix_transpose_128
// 128 x 128 bit matrix store with row write, row read and in-place transpose.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bit_matrix_transpose_128
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  bmt_pkg::cmd_t   cmd,
    output logic            rsp_strobe,
    output bmt_pkg::rsp_t   rsp
);

    bmt_pkg::ctrl_t              ctl;
    logic [bmt_pkg::ROW_W-1:0]   rd_data_a;
    logic [bmt_pkg::ROW_W-1:0]   rd_data_b;
    logic [bmt_pkg::ROW_W-1:0]   new_a;
    logic [bmt_pkg::ROW_W-1:0]   new_b;
    logic [bmt_pkg::ROW_W-1:0]   new_b_reg;
    logic [bmt_pkg::ROW_W-1:0]   wr_data;
    logic                        rd_take;
    logic                        tr_take;
    logic                        strobe_busy;

    bmt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .ctl   (ctl)
    );

    bmt_store u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .wr_data   (wr_data),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    bmt_swap u_swap
    (
        .stage (ctl.stage),
        .row_a (rd_data_a),
        .row_b (rd_data_b),
        .new_a (new_a),
        .new_b (new_b)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.wr_sel == bmt_pkg::WSEL_NEW_A)
        begin
            new_b_reg <= new_b;
        end
    end

    always_comb
    begin
        case (ctl.wr_sel)
            bmt_pkg::WSEL_NEW_A: wr_data = new_a;
            bmt_pkg::WSEL_NEW_B: wr_data = new_b_reg;
            default:             wr_data = {cmd.in_low, cmd.in_high};
        endcase
    end

    assign busy         = ctl.busy;
    assign rsp_strobe   = ctl.rsp_pending;
    assign rsp.out_low  = rd_data_a[bmt_pkg::ROW_W-1:bmt_pkg::HALF_W];
    assign rsp.out_high = rd_data_a[bmt_pkg::HALF_W-1:0];

    assign rd_take     = start && !busy && (cmd.op == bmt_pkg::OP_READ);
    assign tr_take     = start && !busy && (cmd.op == bmt_pkg::OP_TRANSPOSE);
    assign strobe_busy = rsp_strobe && busy;

    `BMT_ASSERT(a_rsp_after_read, clk, rst_n, rsp_strobe |-> $past(rd_take), "stray result strobe")
    `BMT_ASSERT(a_transpose_busy, clk, rst_n, tr_take |=> busy, "transpose did not start")
    `BMT_ASSERT_ALWAYS(a_rsp_not_busy, clk, strobe_busy !== 1'b1, "strobe while busy")

endmodule

FILE: rtl/core/bmt_store.sv
// ---------------------------------------------------------------------------
// bmt_store
// 128 x 128 bit row memory, one write and two registered reads per cycle.
// Per-row valid bits make never-written rows read as zero after reset.
// ---------------------------------------------------------------------------
module bmt_store
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bmt_pkg::ctrl_t               ctl,
    input  logic [bmt_pkg::ROW_W-1:0]    wr_data,
    output logic [bmt_pkg::ROW_W-1:0]    rd_data_a,
    output logic [bmt_pkg::ROW_W-1:0]    rd_data_b
);

    logic [bmt_pkg::ROW_W-1:0] mem [bmt_pkg::ROWS];
    logic [bmt_pkg::ROWS-1:0]  valid_reg;
    logic [bmt_pkg::ROW_W-1:0] rd_a_reg;
    logic [bmt_pkg::ROW_W-1:0] rd_b_reg;
    logic                      vld_a_reg;
    logic                      vld_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_a_reg <= mem[ctl.rd_addr_a];
            rd_b_reg <= mem[ctl.rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[ctl.wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                vld_a_reg <= valid_reg[ctl.rd_addr_a];
                vld_b_reg <= valid_reg[ctl.rd_addr_b];
            end
        end
    end

    assign rd_data_a = vld_a_reg ? rd_a_reg : '0;
    assign rd_data_b = vld_b_reg ? rd_b_reg : '0;

endmodule

FILE: rtl/core/bmt_swap.sv
// ---------------------------------------------------------------------------
// bmt_swap
// Block swap of one row pair for one transpose stage.
// Row word is {low, high}; column c sits at bit 127-c.
// ---------------------------------------------------------------------------
module bmt_swap
(
    input  logic [bmt_pkg::STG_W-1:0]  stage,
    input  logic [bmt_pkg::ROW_W-1:0]  row_a,
    input  logic [bmt_pkg::ROW_W-1:0]  row_b,
    output logic [bmt_pkg::ROW_W-1:0]  new_a,
    output logic [bmt_pkg::ROW_W-1:0]  new_b
);

    logic [bmt_pkg::ROW_W-1:0]  mask;
    logic [bmt_pkg::ADDR_W-1:0] shamt;

    always_comb
    begin
        mask  = bmt_pkg::swap_mask(stage);
        shamt = bmt_pkg::ADDR_W'(1) << stage;
        new_a = (row_a & ~mask) | ((row_b >> shamt) & mask);
        new_b = (row_b & mask) | ((row_a << shamt) & ~mask);
    end

endmodule

FILE: rtl/core/bmt_ctrl.sv
// ---------------------------------------------------------------------------
// bmt_ctrl
// Command decode and transpose sequencer: 7 stages of 64 row-pair swaps.
// ---------------------------------------------------------------------------
module bmt_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  bmt_pkg::cmd_t   cmd,
    output bmt_pkg::ctrl_t  ctl
);

    bmt_pkg::state_t                state_reg, state_next;
    logic [bmt_pkg::STG_W-1:0]      stage_reg, stage_next;
    logic [bmt_pkg::PAIR_W-1:0]     pair_reg, pair_next;
    logic                           rsp_pending_reg, rsp_pending_next;
    logic                           accept;
    logic                           last_pair;
    logic [bmt_pkg::ADDR_W-1:0]     pair_ext;
    logic [bmt_pkg::ADDR_W-1:0]     low_mask;
    logic [bmt_pkg::ADDR_W-1:0]     row_a;
    logic [bmt_pkg::ADDR_W-1:0]     row_b;

    assign accept    = start && (state_reg == bmt_pkg::ST_IDLE);
    assign last_pair = (pair_reg == bmt_pkg::LAST_PAIR);

    // Insert a zero at the stage bit of the pair count.
    always_comb
    begin
        pair_ext = {1'b0, pair_reg};
        low_mask = (bmt_pkg::ADDR_W'(1) << stage_reg) - bmt_pkg::ADDR_W'(1);
        row_a    = ((pair_ext & ~low_mask) << 1) | (pair_ext & low_mask);
        row_b    = row_a | (bmt_pkg::ADDR_W'(1) << stage_reg);
    end

    always_comb
    begin
        state_next       = state_reg;
        stage_next       = stage_reg;
        pair_next        = pair_reg;
        rsp_pending_next = accept && (cmd.op == bmt_pkg::OP_READ);
        unique case (state_reg)
            bmt_pkg::ST_IDLE:
            begin
                if (accept && (cmd.op == bmt_pkg::OP_TRANSPOSE))
                begin
                    state_next = bmt_pkg::ST_RD;
                    stage_next = '0;
                    pair_next  = '0;
                end
            end
            bmt_pkg::ST_RD:
            begin
                state_next = bmt_pkg::ST_WA;
            end
            bmt_pkg::ST_WA:
            begin
                state_next = bmt_pkg::ST_WB;
            end
            bmt_pkg::ST_WB:
            begin
                pair_next = pair_reg + 1'b1;
                if (last_pair)
                begin
                    stage_next = stage_reg + 1'b1;
                end
                if (last_pair && (stage_reg == bmt_pkg::LAST_STAGE))
                begin
                    state_next = bmt_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bmt_pkg::ST_RD;
                end
            end
            default:
            begin
                state_next = bmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl             = '0;
        ctl.busy        = (state_reg != bmt_pkg::ST_IDLE);
        ctl.rsp_pending = rsp_pending_reg;
        ctl.stage       = stage_reg;
        ctl.wr_sel      = bmt_pkg::WSEL_CMD;
        unique case (state_reg)
            bmt_pkg::ST_IDLE:
            begin
                ctl.rd_en     = accept && (cmd.op == bmt_pkg::OP_READ);
                ctl.rd_addr_a = cmd.row_index;
                ctl.rd_addr_b = cmd.row_index;
                ctl.wr_en     = accept && (cmd.op == bmt_pkg::OP_WRITE);
                ctl.wr_addr   = cmd.row_index;
            end
            bmt_pkg::ST_RD:
            begin
                ctl.rd_en     = 1'b1;
                ctl.rd_addr_a = row_a;
                ctl.rd_addr_b = row_b;
            end
            bmt_pkg::ST_WA:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = row_a;
                ctl.wr_sel  = bmt_pkg::WSEL_NEW_A;
            end
            bmt_pkg::ST_WB:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = row_b;
                ctl.wr_sel  = bmt_pkg::WSEL_NEW_B;
            end
            default:
            begin
                ctl.wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bmt_pkg::ST_IDLE;
            stage_reg       <= '0;
            pair_reg        <= '0;
            rsp_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stage_reg       <= stage_next;
            pair_reg        <= pair_next;
            rsp_pending_reg <= rsp_pending_next;
        end
    end

endmodule
